// File: src/wvts_pkg.sv
// Package for the wasm validation type stack: sizes, command/status codes,
// sequencer states, the saved frame record and the type match rule.
// No dependencies.
package wvts_pkg;

  localparam int VALUE_DEPTH     = 1024;
  localparam int FRAME_DEPTH     = 64;
  localparam int MAX_FRAME_TYPES = 8;
  localparam int JUMP_SLOTS      = 4096;

  localparam int VAW = $clog2(VALUE_DEPTH);      // value stack address
  localparam int VCW = VAW + 1;                  // value depth count
  localparam int FAW = $clog2(FRAME_DEPTH);
  localparam int FCW = FAW + 1;
  localparam int ETW = $clog2(MAX_FRAME_TYPES);
  localparam int JAW = $clog2(JUMP_SLOTS);
  localparam int JCW = JAW + 1;
  localparam int PCW = 24;

  // commands
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PFRAME = 3'd2;
  localparam logic [2:0] CMD_FTYPE  = 3'd3;
  localparam logic [2:0] CMD_END    = 3'd4;
  localparam logic [2:0] CMD_ELSE   = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_HEIGHT   = 3'd3;
  localparam logic [2:0] ST_IFELSE   = 3'd4;
  localparam logic [2:0] ST_NOFRAME  = 3'd5;
  localparam logic [2:0] ST_OVER     = 3'd6;

  // value types
  localparam logic [3:0] VT_UNKNOWN   = 4'd0;
  localparam logic [3:0] VT_LAST_REAL = 4'd7;
  localparam logic [3:0] VT_FUNCREF   = 4'd6;
  localparam logic [3:0] VT_EXTERNREF = 4'd7;
  localparam logic [3:0] VT_ANYREF    = 4'd8;

  // frame kinds
  localparam logic [2:0] FK_BLOCK = 3'd0;
  localparam logic [2:0] FK_IF    = 3'd2;
  localparam logic [2:0] FK_ELSE  = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_POP, S_SLOT2, S_JPC, S_ELOOP, S_ECMP, S_RELOAD, S_FIN
  } state_t;

  // frame record saved below the top of the frame stack
  typedef struct packed {
    logic [2:0]     kind;
    logic [VCW-1:0] height;
    logic           unr;
    logic [JAW-1:0] slot;
    logic [3:0]     ecnt;    // end types expected
    logic [3:0]     ewr;     // end types written so far
  } frame_t;

  // expected type against found type
  function automatic logic type_ok(input logic [3:0] exp_t, input logic [3:0] got_t);
    type_ok = (exp_t == VT_UNKNOWN) || (got_t == VT_UNKNOWN) || (got_t == exp_t) ||
              ((exp_t == VT_ANYREF) && ((got_t == VT_FUNCREF) || (got_t == VT_EXTERNREF)));
  endfunction

endpackage

// File: src/wasm_validation_type_stack.sv
// wasm validation type stack: operand type stack and control frame stack.
// Channels: in_* word carries one command, out_* word one result per command,
// cfg_* is an APB-style register port (register 0: jump_table_enable).
// A small sequencer drives one value-stack port, one frame-record port, one
// end-type port and one jump-slot pc port; each memory read is registered.
// Flow: S_EXEC decodes each command and S_FIN registers its result; push, push
// frame, frame type, mark unreachable and errors found in S_EXEC go straight
// to S_FIN. A pop reads in S_POP, an if with jump slots writes its second pc in
// S_SLOT2; end and else read a hit jump slot's pc, walk the end types and reload
// any enclosing frame. One command is in work at a time and the next word is
// taken once the result is registered; the end-type walk is the longest case.
// in_tready is high only while the sequencer is idle. A finished result sits
// in the output register while the next word is taken; if the receiver still
// stalls when that next result is ready, the sequencer waits for it.
// Reset (rst_n low, synchronous) empties both stacks, frees all jump slots,
// clears the peaks and the register; no clearing pass is needed.
// Depends on wvts_pkg.
module wasm_validation_type_stack
  import wvts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], value_type[6:3], frame_kind[9:7], code_pc[33:10],
  // given_slot[45:34], start_count[49:46], end_count[53:50], zeros above
  input  logic [55:0] in_tdata,
  // make_unreachable[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], popped_type[5:3], jump_slot[17:6], jump_pc[41:18],
  // jump_target[65:42], max_values[76:66], max_frames[83:77],
  // popped_kind[86:84], zero above
  output logic [87:0] out_tdata,
  // jump_valid[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  state_t state_r, state_nxt;

  // configuration
  logic jte_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, jte_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jte_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      jte_r <= cfg_pwdata[0];
    end
  end

  // command word
  logic [2:0]     cmd_r, cmd_nxt, kind_r, kind_nxt;
  logic [3:0]     vt_r, vt_nxt, sc_r, sc_nxt, ec_r, ec_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic [JAW-1:0] gs_r, gs_nxt;
  logic           mu_r, mu_nxt;

  // engine state
  logic [VCW-1:0] tdepth_r, tdepth_nxt, peakv_r, peakv_nxt;
  logic [FCW-1:0] fdepth_r, fdepth_nxt, peakf_r, peakf_nxt;
  logic [JCW-1:0] slots_r, slots_nxt;
  logic [4:0]     pend_r, pend_nxt;
  frame_t         top_r, top_nxt;
  logic [3:0]     i_r, i_nxt;
  logic           ecv_r, ecv_nxt;

  // result being built
  logic [2:0]     st_r, st_nxt, pt_r, pt_nxt, pk_r, pk_nxt;
  logic           jv_r, jv_nxt;
  logic [JAW-1:0] js_r, js_nxt;
  logic [PCW-1:0] jpc_r, jpc_nxt, jt_r, jt_nxt;

  // output register
  logic           ov_r;
  logic [87:0]    od_r;
  logic           ou_r;

  // memories
  logic [3:0]     tmem [VALUE_DEPTH];
  logic           tm_we;
  logic [VAW-1:0] tm_addr;
  logic [3:0]     tm_wd, tm_q;
  frame_t         fmem [FRAME_DEPTH];
  logic           fm_we;
  logic [FAW-1:0] fm_addr;
  frame_t         fm_q;
  logic [3:0]     emem [FRAME_DEPTH*MAX_FRAME_TYPES];
  logic           em_we;
  logic [FAW+ETW-1:0] em_addr;
  logic [3:0]     em_q;
  logic [PCW-1:0] pmem [JUMP_SLOTS];
  logic           pm_we;
  logic [JAW-1:0] pm_addr;
  logic [PCW-1:0] pm_wd, pm_q;

  always_ff @(posedge clk) begin
    if (tm_we) tmem[tm_addr] <= tm_wd;
    tm_q <= tmem[tm_addr];
  end
  always_ff @(posedge clk) begin
    if (fm_we) fmem[fm_addr] <= top_r;
    fm_q <= fmem[fm_addr];
  end
  always_ff @(posedge clk) begin
    if (em_we) emem[em_addr] <= vt_r;
    em_q <= emem[em_addr];
  end
  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_addr] <= pm_wd;
    pm_q <= pmem[pm_addr];
  end

  // shared decisions
  logic           accept, no_frame, pop_empty, else_bad, pf_ovf, jmp_hit, out_free;
  logic [1:0]     nslots;
  logic [JCW:0]   slot_sum;
  logic [JCW-1:0] jidx;
  logic [FAW-1:0] fd_top;
  logic [3:0]     sc_sat, ec_sat, e_idx;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !ov_r || out_tready;
  assign no_frame  = (fdepth_r == '0);
  assign pop_empty = (tdepth_r <= top_r.height);
  assign else_bad  = (cmd_r == CMD_ELSE) && (top_r.kind != FK_IF);
  assign fd_top    = fdepth_r[FAW-1:0] - 1'b1;
  assign nslots    = !jte_r ? 2'd0 : (kind_r == FK_BLOCK) ? 2'd1 :
                     (kind_r == FK_IF) ? 2'd2 : 2'd0;
  assign slot_sum  = {1'b0, slots_r} + {{(JCW-1){1'b0}}, nslots};
  assign pf_ovf    = (fdepth_r >= FCW'(FRAME_DEPTH)) || (slot_sum > (JCW+1)'(JUMP_SLOTS));
  assign jidx      = {1'b0, top_r.slot} + {{(JCW-1){1'b0}}, (cmd_r == CMD_ELSE)};
  assign jmp_hit   = (slots_r != '0) && (jidx < slots_r) &&
                     ((top_r.kind == FK_BLOCK) || (top_r.kind == FK_IF) ||
                      (top_r.kind == FK_ELSE));
  assign sc_sat    = (sc_r > 4'(MAX_FRAME_TYPES)) ? 4'(MAX_FRAME_TYPES) : sc_r;
  assign ec_sat    = (ec_r > 4'(MAX_FRAME_TYPES)) ? 4'(MAX_FRAME_TYPES) : ec_r;
  assign e_idx     = top_r.ecnt - pend_r[3:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (cmd_r)
          CMD_POP:    state_nxt = (no_frame || mu_r || pop_empty) ? S_FIN : S_POP;
          CMD_PFRAME: state_nxt = (!pf_ovf && nslots == 2'd2) ? S_SLOT2 : S_FIN;
          CMD_END, CMD_ELSE: begin
            if (no_frame || else_bad) state_nxt = S_FIN;
            else state_nxt = jmp_hit ? S_JPC : S_ELOOP;
          end
          default:    state_nxt = S_FIN;
        endcase
      end
      S_POP, S_SLOT2, S_RELOAD: state_nxt = S_FIN;
      S_JPC:  state_nxt = S_ELOOP;
      S_ELOOP: begin
        priority if (i_r == '0) begin
          state_nxt = (tdepth_r != top_r.height || fdepth_r == FCW'(1)) ? S_FIN : S_RELOAD;
        end else if (pop_empty) begin
          state_nxt = top_r.unr ? S_ELOOP : S_FIN;
        end else begin
          state_nxt = S_ECMP;
        end
      end
      S_ECMP: state_nxt = type_ok(ecv_r ? em_q : VT_UNKNOWN, tm_q) ? S_ELOOP : S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic do_push;
    do_push = 1'b0;
    cmd_nxt = cmd_r; vt_nxt = vt_r; kind_nxt = kind_r; pc_nxt = pc_r; gs_nxt = gs_r;
    sc_nxt = sc_r; ec_nxt = ec_r; mu_nxt = mu_r;
    tdepth_nxt = tdepth_r; peakv_nxt = peakv_r; fdepth_nxt = fdepth_r; peakf_nxt = peakf_r;
    slots_nxt = slots_r; pend_nxt = pend_r; top_nxt = top_r; i_nxt = i_r; ecv_nxt = ecv_r;
    st_nxt = st_r; pt_nxt = pt_r; pk_nxt = pk_r; jv_nxt = jv_r; js_nxt = js_r;
    jpc_nxt = jpc_r; jt_nxt = jt_r;
    tm_we = 1'b0; tm_addr = tdepth_r[VAW-1:0]; tm_wd = vt_r;
    fm_we = 1'b0; fm_addr = fd_top;
    em_we = 1'b0; em_addr = {fd_top, e_idx[ETW-1:0]};
    pm_we = 1'b0; pm_addr = slots_r[JAW-1:0]; pm_wd = pc_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_tdata[2:0];
          vt_nxt   = in_tdata[6:3];
          kind_nxt = in_tdata[9:7];
          pc_nxt   = in_tdata[33:10];
          gs_nxt   = in_tdata[45:34];
          sc_nxt   = in_tdata[49:46];
          ec_nxt   = in_tdata[53:50];
          mu_nxt   = in_tuser;
          st_nxt = ST_OK; pt_nxt = '0; pk_nxt = '0; jv_nxt = 1'b0;
          js_nxt = '0; jpc_nxt = '0; jt_nxt = '0;
        end
      end

      S_EXEC: begin
        if (cmd_r != CMD_FTYPE) pend_nxt = '0;
        unique case (cmd_r)
          CMD_PUSH: begin
            if (no_frame) st_nxt = ST_NOFRAME;
            else do_push = 1'b1;
          end
          CMD_POP: begin
            priority if (no_frame) begin
              st_nxt = ST_NOFRAME;
            end else if (mu_r) begin
              tdepth_nxt = top_r.height;
              top_nxt.unr = 1'b1;
            end else if (pop_empty) begin
              st_nxt = top_r.unr ? ST_OK : ST_UNDER;
            end else begin
              tdepth_nxt = tdepth_r - 1'b1;
              tm_addr    = tdepth_nxt[VAW-1:0];
            end
          end
          CMD_PFRAME: begin
            if (pf_ovf) begin
              st_nxt = ST_OVER;
            end else begin
              top_nxt.slot = gs_r;
              if (nslots != 2'd0) begin
                pm_we = 1'b1;
                top_nxt.slot = slots_r[JAW-1:0];
                slots_nxt = slot_sum[JCW-1:0];
                jv_nxt = 1'b1; js_nxt = slots_r[JAW-1:0]; jpc_nxt = pc_r;
              end
              // spill the old top frame
              if (!no_frame) fm_we = 1'b1;
              top_nxt.kind   = kind_r;
              top_nxt.height = tdepth_r;
              top_nxt.unr    = 1'b0;
              top_nxt.ecnt   = ec_sat;
              top_nxt.ewr    = '0;
              fdepth_nxt = fdepth_r + 1'b1;
              if (fdepth_nxt > peakf_r) peakf_nxt = fdepth_nxt;
              pend_nxt = {1'b0, sc_sat} + {1'b0, ec_sat};
            end
          end
          CMD_FTYPE: begin
            if (pend_r != '0 && !no_frame) begin
              if (pend_r > {1'b0, top_r.ecnt}) begin
                do_push = 1'b1;
              end else begin
                em_we = 1'b1;
                top_nxt.ewr = e_idx + 1'b1;
              end
              pend_nxt = pend_r - 1'b1;
            end
          end
          CMD_END, CMD_ELSE: begin
            priority if (no_frame) begin
              st_nxt = ST_NOFRAME;
            end else if (else_bad) begin
              st_nxt = ST_IFELSE;
            end else begin
              if (jmp_hit) begin
                jv_nxt = 1'b1; js_nxt = jidx[JAW-1:0]; jt_nxt = pc_r;
                pm_addr = jidx[JAW-1:0];
              end
              i_nxt = top_r.ecnt;
            end
          end
          default: ;
        endcase
        // push one value type
        if (do_push) begin
          priority if (vt_r > VT_LAST_REAL) begin
            st_nxt = ST_MISMATCH;
          end else if (tdepth_r >= VCW'(VALUE_DEPTH)) begin
            st_nxt = ST_OVER;
          end else begin
            tm_we = 1'b1;
            tdepth_nxt = tdepth_r + 1'b1;
            if (!top_r.unr && tdepth_nxt > peakv_r) peakv_nxt = tdepth_nxt;
          end
        end
      end

      S_POP: begin
        pt_nxt = tm_q[2:0];
        if (!type_ok(vt_r, tm_q)) st_nxt = ST_MISMATCH;
      end

      S_SLOT2: begin
        pm_we   = 1'b1;
        pm_addr = top_r.slot + 1'b1;
        pm_wd   = pc_r + 1'b1;
      end

      S_JPC: jpc_nxt = pm_q;

      // walk stored end types from the last one down
      S_ELOOP: begin
        priority if (i_r == '0) begin
          if (tdepth_r != top_r.height) begin
            st_nxt = ST_HEIGHT;
          end else begin
            fdepth_nxt = fdepth_r - 1'b1;
            pk_nxt = top_r.kind;
            fm_addr = fdepth_r[FAW-1:0] - 2'd2;
          end
        end else if (pop_empty) begin
          if (top_r.unr) i_nxt = i_r - 1'b1;
          else st_nxt = ST_UNDER;
        end else begin
          tdepth_nxt = tdepth_r - 1'b1;
          tm_addr = tdepth_nxt[VAW-1:0];
          em_addr = {fd_top, 3'(i_r - 1'b1)};
          ecv_nxt = (i_r - 1'b1) < top_r.ewr;
        end
      end

      S_ECMP: begin
        if (type_ok(ecv_r ? em_q : VT_UNKNOWN, tm_q)) i_nxt = i_r - 1'b1;
        else st_nxt = ST_MISMATCH;
      end

      S_RELOAD: top_nxt = fm_q;

      S_FIN: ;
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tdepth_r <= '0;
      fdepth_r <= '0;
      slots_r  <= '0;
      pend_r   <= '0;
      peakv_r  <= '0;
      peakf_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tdepth_r <= tdepth_nxt;
      fdepth_r <= fdepth_nxt;
      slots_r  <= slots_nxt;
      pend_r   <= pend_nxt;
      peakv_r  <= peakv_nxt;
      peakf_r  <= peakf_nxt;
      if (state_r == S_FIN && out_free) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; vt_r <= vt_nxt; kind_r <= kind_nxt; pc_r <= pc_nxt;
    gs_r <= gs_nxt; sc_r <= sc_nxt; ec_r <= ec_nxt; mu_r <= mu_nxt;
    top_r <= top_nxt; i_r <= i_nxt; ecv_r <= ecv_nxt;
    st_r <= st_nxt; pt_r <= pt_nxt; pk_r <= pk_nxt; jv_r <= jv_nxt;
    js_r <= js_nxt; jpc_r <= jpc_nxt; jt_r <= jt_nxt;
    if (state_r == S_FIN && out_free) begin
      od_r <= {1'b0, pk_r, peakf_r, peakv_r, jt_r, jpc_r, js_r, pt_r, st_r};
      ou_r <= jv_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule
